// ----- design/itrs_pkg.sv -----
package itrs_pkg;
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_CONVERT = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  symbol;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       status;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_APPEND,
        ST_DIV,
        ST_LOOK,
        ST_STORE,
        ST_SIGN,
        ST_READ,
        ST_EMIT,
        ST_STATUS
    } t_state;

    function automatic logic is_forbidden(input logic [7:0] b);
        return b == CH_PLUS || b == CH_MINUS || b == CH_SPACE ||
               (b >= CH_TAB && b <= CH_CR);
    endfunction
endpackage

// ----- design/itrs_if.sv -----
interface itrs_in_if;
    import itrs_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface itrs_out_if;
    import itrs_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/integer_to_radix_string.sv -----
// Clear sweeps the seen-map, one entry per cycle; append registers the symbol, then stores it.
// Convert computes each digit with the radix-2 restoring divider, looks it up in the symbol
// table and stores it; each emitted character is read back through the digit memory.
// One command is handled at a time; the output register holds a beat until taken.
// Reset (synchronous, active low) returns control to idle with an empty alphabet;
// the seen-map is swept clear after reset before the first command.
module integer_to_radix_string #(
    parameter int MAX_SYMBOLS = 256
) (
    input logic i_clk,
    input logic i_rst_n,
    itrs_in_if.sink    in_ch,
    itrs_out_if.source out_ch
);
    import itrs_pkg::*;

    logic [7:0] symbol_table [256];
    logic       seen_map     [256];
    logic [7:0] digit_buffer [32];

    t_state      r_state, n_state;
    logic [8:0]  r_count, n_count;
    logic        r_bad, n_bad;
    logic [8:0]  r_clr, n_clr;
    logic [7:0]  r_sym;
    logic        r_neg;
    logic [31:0] r_mag, n_mag;
    logic [5:0]  r_ndig, n_ndig;
    logic        r_ovalid, n_ovalid;
    t_out        r_odata, n_odata;

    logic        w_div_start, w_div_done;
    logic [31:0] w_quo;
    logic [8:0]  w_rem;
    logic [31:0] w_abs;
    logic [31:0] w_dividend;
    logic [7:0]  r_tab_rd, r_dig_rd;
    logic        r_seen_rd;
    logic [7:0]  w_tab_addr;
    logic [4:0]  w_dig_addr;
    logic        w_seen_we, w_seen_val, w_tab_we, w_dig_we;
    logic [7:0]  w_seen_addr;
    logic [7:0]  r_rem8;
    logic        w_accept;

    itrs_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (r_count),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign in_ch.ready  = r_state == ST_IDLE && !r_ovalid && r_clr == 9'd256;
    assign w_accept     = in_ch.valid && in_ch.ready;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;
    assign w_abs        = in_ch.data.value[31] ? 32'(-in_ch.data.value) : in_ch.data.value;
    assign w_dividend   = (r_state == ST_IDLE) ? w_abs : r_mag;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (r_clr != 9'd256) begin
                    n_state = ST_CLEAR;
                end else if (w_accept) begin
                    case (in_ch.data.cmd)
                        CMD_CLEAR:   n_state = ST_CLEAR;
                        CMD_APPEND:  n_state = (r_count >= 9'(MAX_SYMBOLS)) ? ST_IDLE
                                                                            : ST_APPEND;
                        CMD_CONVERT: begin
                            if (r_count < 9'd2 || r_bad) begin
                                n_state = ST_STATUS;
                            end else begin
                                n_state = ST_DIV;
                            end
                        end
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:  n_state = (r_clr == 9'd255) ? ST_IDLE : ST_CLEAR;
            ST_APPEND: n_state = ST_IDLE;
            ST_DIV:    n_state = w_div_done ? ST_LOOK : ST_DIV;
            ST_LOOK:   n_state = ST_STORE;
            ST_STORE:  n_state = (r_mag == '0 || r_ndig == 6'd31) ? (r_neg ? ST_SIGN : ST_READ)
                                                                  : ST_DIV;
            ST_SIGN:   n_state = r_ovalid ? ST_SIGN : ST_READ;
            ST_READ:   n_state = r_ovalid ? ST_READ : ST_EMIT;
            ST_EMIT:   n_state = (r_ndig == 6'd0) ? ST_IDLE : ST_READ;
            ST_STATUS: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_bad    = r_bad;
        n_clr    = r_clr;
        n_mag    = r_mag;
        n_ndig   = r_ndig;
        n_ovalid = r_ovalid && !out_ch.ready;
        n_odata  = r_odata;
        w_div_start = 1'b0;
        w_seen_we   = 1'b0;
        w_seen_val  = 1'b0;
        w_seen_addr = r_clr[7:0];
        w_tab_we    = 1'b0;
        w_tab_addr  = r_count[7:0];
        w_dig_we    = 1'b0;
        w_dig_addr  = r_ndig[4:0];
        case (r_state)
            ST_IDLE: begin
                w_seen_addr = in_ch.data.symbol;
                if (w_accept) begin
                    if (in_ch.data.cmd == CMD_CLEAR) begin
                        n_count = '0;
                        n_bad   = 1'b0;
                        n_clr   = '0;
                    end
                    n_mag  = w_abs;
                    n_ndig = '0;
                end
            end
            ST_CLEAR: begin
                w_seen_we   = 1'b1;
                w_seen_addr = r_clr[7:0];
                n_clr       = r_clr + 9'd1;
            end
            ST_APPEND: begin
                w_seen_addr = r_sym;
                w_seen_we   = 1'b1;
                w_seen_val  = 1'b1;
                w_tab_we    = 1'b1;
                if (r_seen_rd || is_forbidden(r_sym)) begin
                    n_bad = 1'b1;
                end
                n_count = r_count + 9'd1;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_mag = w_quo;
                end
            end
            ST_LOOK: begin
                w_tab_addr = r_rem8;
            end
            ST_STORE: begin
                w_dig_we = 1'b1;
                n_ndig   = r_ndig + 6'd1;
                if (!(r_mag == '0 || r_ndig == 6'd31)) begin
                    w_div_start = 1'b1;
                end
            end
            ST_SIGN: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_odata  = '{character: CH_MINUS, last: 1'b0, status: 1'b0};
                end
            end
            ST_READ: begin
                w_dig_addr = 5'(r_ndig - 6'd1);
                if (!r_ovalid) begin
                    n_ndig = r_ndig - 6'd1;
                end
            end
            ST_EMIT: begin
                n_ovalid = 1'b1;
                n_odata  = '{character: r_dig_rd, last: r_ndig == 6'd0, status: 1'b0};
            end
            ST_STATUS: begin
                n_ovalid = 1'b1;
                n_odata  = '{character: 8'd0, last: 1'b1, status: 1'b1};
            end
            default: ;
        endcase
        if (w_accept && in_ch.data.cmd == CMD_CONVERT && !(r_count < 9'd2 || r_bad)) begin
            w_div_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seen_we) begin
            seen_map[w_seen_addr] <= w_seen_val;
        end
        r_seen_rd <= seen_map[w_seen_addr];
        if (w_tab_we) begin
            symbol_table[w_tab_addr] <= r_sym;
        end
        r_tab_rd <= symbol_table[w_tab_addr];
        if (w_dig_we) begin
            digit_buffer[w_dig_addr] <= r_tab_rd;
        end
        r_dig_rd <= digit_buffer[w_dig_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_bad    <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_bad    <= n_bad;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_mag   <= n_mag;
        r_ndig  <= n_ndig;
        r_odata <= n_odata;
        if (w_accept) begin
            r_sym <= in_ch.data.symbol;
            r_neg <= in_ch.data.value[31];
        end
        if (w_div_done) begin
            r_rem8 <= w_rem[7:0];
        end
    end
endmodule

// ----- design/itrs_divider.sv -----
module itrs_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [8:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [8:0]  o_remainder
);
    logic [31:0] r_quo, n_quo;
    logic [8:0]  r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [9:0]  w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_quo[31]};
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = 9'(w_trial - {1'b0, i_divisor});
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_trial[8:0];
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done      = r_busy && r_cnt == 6'd1;
    assign o_quotient  = n_quo;
    assign o_remainder = n_rem;
endmodule
